>>> rtl/assert_macros.svh
// Assertion macros used by the debounce state machine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/bdf_pkg.sv
// Types and constants of the button debounce state machine
`default_nettype none

package bdf_pkg;

    localparam int TIME_W = 32;
    localparam int DBT_W  = 16;

    localparam logic [DBT_W-1:0] DEBOUNCE_RESET = 16'd50;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESS_DB = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_REL_DB   = 2'd3
    } phase_t;

    typedef struct packed {
        logic              button_level;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        fsm_state;
        logic              press_event;
        logic              release_event;
        logic              led_on;
        logic [TIME_W-1:0] presses_total;
        logic [TIME_W-1:0] hold_duration_ms;
    } out_word_t;

endpackage

`default_nettype wire

>>> rtl/button_debounce_fsm_top.sv
// Top level of the button debounce state machine
// Takes one button sample word per clock while in_stall is low, with no gap needed between
// words, and returns one result word per sample. The sample is held in an input register.
// The state machine (a 32-bit timestamp subtract, a compare with the debounce time and the
// phase update) works on it combinationally, and its result is loaded into the result
// register when that is free; the result register drives out_valid and the result word.
// While out_stall holds a result word, the input register holds too. Once that register
// already has a sample waiting, in_stall rises in the same cycle, so at most two words are
// in flight. The debounce time register resets to 50 ms and may be written whenever no
// sample is in flight.
`default_nettype none

module button_debounce_fsm_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire bdf_pkg::in_word_t           in_data,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      bdf_pkg::out_word_t          out_data,
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [bdf_pkg::DBT_W-1:0]   cfg_data
);

    logic                          in_vld_reg;
    bdf_pkg::in_word_t             in_word_reg;
    logic                          out_vld_reg;
    bdf_pkg::out_word_t            out_word_reg;
    logic [bdf_pkg::DBT_W-1:0]     dbt_reg;
    logic                          out_free;
    logic                          advance;
    bdf_pkg::out_word_t            fsm_result;

    assign out_free  = !out_vld_reg || !out_stall;
    assign advance   = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

    bdf_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .word          (in_word_reg),
        .debounce_time (dbt_reg),
        .result        (fsm_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            dbt_reg     <= bdf_pkg::DEBOUNCE_RESET;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (out_free)
                out_vld_reg <= in_vld_reg;
            if (cfg_valid && cfg_ready)
                dbt_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_word_reg <= in_data;
        if (advance)
            out_word_reg <= fsm_result;
    end

endmodule

`default_nettype wire

>>> rtl/bdf_fsm.sv
// Debounce state machine: phase, timestamps, press count and LED flag
`default_nettype none
`include "assert_macros.svh"

module bdf_fsm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire bdf_pkg::in_word_t           word,
    input  wire logic [bdf_pkg::DBT_W-1:0]   debounce_time,
    output bdf_pkg::out_word_t               result
);

    bdf_pkg::phase_t                 phase_reg, phase_next;
    logic                            prev_level_reg;
    logic [bdf_pkg::TIME_W-1:0]      db_start_reg, db_start_next;
    logic [bdf_pkg::TIME_W-1:0]      press_start_reg, press_start_next;
    logic [bdf_pkg::TIME_W-1:0]      counter_reg, counter_next;
    logic                            led_reg, led_next;

    logic [bdf_pkg::TIME_W-1:0]      elapsed_ms;
    logic                            elapsed;
    logic                            level;

    assign level      = word.button_level;
    assign elapsed_ms = word.now_ms - db_start_reg;
    assign elapsed    = elapsed_ms >= {{(bdf_pkg::TIME_W-bdf_pkg::DBT_W){1'b0}}, debounce_time};

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            bdf_pkg::PH_IDLE:
            begin
                if (!level && prev_level_reg)
                    phase_next = bdf_pkg::PH_PRESS_DB;
            end
            bdf_pkg::PH_PRESS_DB:
            begin
                if (elapsed)
                    phase_next = level ? bdf_pkg::PH_IDLE : bdf_pkg::PH_PRESSED;
            end
            bdf_pkg::PH_PRESSED:
            begin
                if (level)
                    phase_next = bdf_pkg::PH_REL_DB;
            end
            bdf_pkg::PH_REL_DB:
            begin
                if (elapsed)
                    phase_next = level ? bdf_pkg::PH_IDLE : bdf_pkg::PH_PRESSED;
            end
            default:
            begin
                phase_next = bdf_pkg::PH_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        db_start_next           = db_start_reg;
        press_start_next        = press_start_reg;
        counter_next            = counter_reg;
        led_next                = led_reg;
        result.press_event      = 1'b0;
        result.release_event    = 1'b0;
        result.hold_duration_ms = '0;
        case (phase_reg)
            bdf_pkg::PH_IDLE:
            begin
                if (!level && prev_level_reg)
                    db_start_next = word.now_ms;
            end
            bdf_pkg::PH_PRESS_DB:
            begin
                if (elapsed && !level)
                begin
                    press_start_next   = word.now_ms;
                    counter_next       = counter_reg + 1'b1;
                    led_next           = !led_reg;
                    result.press_event = 1'b1;
                end
            end
            bdf_pkg::PH_PRESSED:
            begin
                if (level)
                    db_start_next = word.now_ms;
            end
            bdf_pkg::PH_REL_DB:
            begin
                if (elapsed && level)
                begin
                    result.release_event    = 1'b1;
                    result.hold_duration_ms = word.now_ms - press_start_reg;
                end
            end
            default:
            begin
                result.press_event = 1'b0;
            end
        endcase
        result.fsm_state     = phase_next;
        result.led_on        = led_next;
        result.presses_total = counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= bdf_pkg::PH_IDLE;
            prev_level_reg  <= 1'b1;
            db_start_reg    <= '0;
            press_start_reg <= '0;
            counter_reg     <= '0;
            led_reg         <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            prev_level_reg  <= level;
            db_start_reg    <= db_start_next;
            press_start_reg <= press_start_next;
            counter_reg     <= counter_next;
            led_reg         <= led_next;
        end
    end

    `ASSERT_NEVER(a_events_exclusive, clk, rst_n, result.press_event && result.release_event, "press and release on one word")
    `ASSERT_PROP(a_count_step, clk, rst_n, advance && result.press_event |=> counter_reg == $past(counter_reg) + 1'b1, "press count did not advance")
    `ASSERT_PROP(a_led_follows_press, clk, rst_n, advance && !result.press_event |=> $stable(led_reg) && $stable(counter_reg), "LED or count moved without a press")
    `ASSERT_PROP(a_hold_when_idle, clk, rst_n, !advance |=> $stable(phase_reg) && $stable(db_start_reg), "state moved without a word")

endmodule

`default_nettype wire
